### src/dihedral_angle_unit_assert.svh
// Assertion macros for the dihedral angle unit.
`ifndef DIHEDRAL_ANGLE_UNIT_ASSERT_SVH
`define DIHEDRAL_ANGLE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define DAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dihedral angle unit: assertion failed");
`define DAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dihedral angle unit: assertion failed");
`else
`define DAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/dau_pkg.sv
// Shared widths, types and constants of the dihedral angle unit.
package dau_pkg;
	localparam int CW       = 24;   // coordinate width
	localparam int BW       = 25;   // bond vector component
	localparam int PW       = 50;   // bond product
	localparam int NW       = 51;   // raw normal component, signed
	localparam int NMW      = 50;   // raw normal magnitude
	localparam int TPH_W    = 50;
	localparam int TPL_W    = 52;
	localparam int TW       = 80;   // exact triple product
	localparam int TP_SPLIT = 26;
	localparam int UW       = 31;   // normalized component, signed
	localparam int UMW      = 30;
	localparam int UPW      = 62;   // product of normalized components
	localparam int CCW      = 63;
	localparam int MW31     = 31;
	localparam int DOTW     = 64;
	localparam int XW       = 33;
	localparam int SQW      = 62;
	localparam int RAD_W    = 64;
	localparam int ROOT_W   = 32;
	localparam int REM_W    = 34;
	localparam int DW       = 36;   // CORDIC datapath
	localparam int ZCW      = 32;
	localparam int PRODW    = 62;
	localparam int OUT_W    = 24;
	localparam int NORM_MSB = 29;
	localparam int CORDIC_N = 30;
	localparam int SQRT_N   = 32;
	localparam int FRONT_LAT = 9;
	localparam int ANGLE_FRAC_BITS_DEF = 14;
	localparam int OUT_MAX  = 8388607;

	localparam logic [ZCW-1:0] PI_Q30      = 32'd3373259426;
	localparam logic [ZCW-1:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [29:0]    DEG_PER_RAD_Q24 = 30'd961263669;

	localparam logic [31:0] ATAN_Q30 [CORDIC_N] = '{
		32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
		32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
		32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535,
		32'd32767, 32'd16383, 32'd8191, 32'd4095, 32'd2047,
		32'd1023, 32'd511, 32'd255, 32'd127, 32'd63,
		32'd31, 32'd15, 32'd7, 32'd3, 32'd1
	};

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		logic                 degen;
		logic                 neg;
		logic signed [XW-1:0] x;
	} sq_side_t;

	typedef struct packed {
		logic degen;
		logic neg;
	} rot_side_t;
endpackage

### src/dau_pts_if.sv
// Input channel: four points per beat.
interface dau_pts_if;
	import dau_pkg::*;
	logic   valid;
	logic   ready;
	coord_t p1_x, p1_y, p1_z, p2_x, p2_y, p2_z;
	coord_t p3_x, p3_y, p3_z, p4_x, p4_y, p4_z;
	modport source (output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
		p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, input ready);
	modport sink (input valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
		p3_x, p3_y, p3_z, p4_x, p4_y, p4_z, output ready);
endinterface

### src/dau_ang_if.sv
// Output channel: one angle per beat.
interface dau_ang_if;
	import dau_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] torsion_angle;
	logic                    degenerate;
	modport source (output valid, torsion_angle, degenerate, input ready);
	modport sink (input valid, torsion_angle, degenerate, output ready);
endinterface

### src/dau_front.sv
// Front pipeline: bond vectors, normals, normalization, cross/dot and sum of squares.
module dau_front (
	input  logic                     clk,
	input  logic                     en,
	input  dau_pkg::coord_t          pt [4][3],
	output logic [dau_pkg::RAD_W-1:0] rad_s9,
	output dau_pkg::sq_side_t        side_s9
);
	import dau_pkg::*;

	localparam int NXT [3] = '{1, 2, 0};
	localparam int PRV [3] = '{2, 0, 1};

	function automatic logic [5:0] msb_pos(input logic [NMW-1:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < NMW; i++)
			if (v[i]) p = 6'(i);
		return p;
	endfunction

	// S1: bond vectors
	logic signed [BW-1:0] b1_s1 [3], b2_s1 [3], b3_s1 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				b1_s1[j] <= BW'(pt[0][j]) - BW'(pt[1][j]);
				b2_s1[j] <= BW'(pt[3][j]) - BW'(pt[2][j]);
				b3_s1[j] <= BW'(pt[2][j]) - BW'(pt[1][j]);
			end
		end
	end

	// S2: cross products, k = 0 n1, 1 n2, 2 triple-product vector
	logic signed [PW-1:0] pa_s2 [3][3], pb_s2 [3][3];
	logic signed [BW-1:0] b3_s2 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				pa_s2[0][j] <= PW'(b3_s1[NXT[j]]) * PW'(b2_s1[PRV[j]]);
				pb_s2[0][j] <= PW'(b3_s1[PRV[j]]) * PW'(b2_s1[NXT[j]]);
				pa_s2[1][j] <= PW'(b3_s1[NXT[j]]) * PW'(b1_s1[PRV[j]]);
				pb_s2[1][j] <= PW'(b3_s1[PRV[j]]) * PW'(b1_s1[NXT[j]]);
				pa_s2[2][j] <= PW'(b1_s1[NXT[j]]) * PW'(b2_s1[PRV[j]]);
				pb_s2[2][j] <= PW'(b1_s1[PRV[j]]) * PW'(b2_s1[NXT[j]]);
				b3_s2[j]    <= b3_s1[j];
			end
		end
	end

	// S3: differences
	logic signed [NW-1:0] n_s3 [3][3];
	logic signed [BW-1:0] b3_s3 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++)
				for (int j = 0; j < 3; j++)
					n_s3[k][j] <= NW'(pa_s2[k][j]) - NW'(pb_s2[k][j]);
			b3_s3 <= b3_s2;
		end
	end

	// S4: magnitudes, leading one of each normal, triple product partials
	logic [NMW-1:0] mag [2][3];
	logic [NMW-1:0] mx [2];
	logic signed [BW-1:0]        tp_hi [3];
	logic signed [TP_SPLIT:0]    tp_lo [3];
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			for (int j = 0; j < 3; j++)
				mag[k][j] = n_s3[k][j][NW-1] ? NMW'(-n_s3[k][j]) : NMW'(n_s3[k][j]);
			mx[k] = mag[k][0];
			if (mag[k][1] > mx[k]) mx[k] = mag[k][1];
			if (mag[k][2] > mx[k]) mx[k] = mag[k][2];
		end
		for (int j = 0; j < 3; j++) begin
			tp_hi[j] = BW'(n_s3[2][j] >>> TP_SPLIT);
			tp_lo[j] = $signed({1'b0, n_s3[2][j][TP_SPLIT-1:0]});
		end
	end

	logic [NMW-1:0]          mag_s4 [2][3];
	logic                    sgn_s4 [2][3];
	logic [5:0]              pos_s4 [2];
	logic                    degen_s4;
	logic signed [TPH_W-1:0] tph_s4 [3];
	logic signed [TPL_W-1:0] tpl_s4 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++) begin
				for (int j = 0; j < 3; j++) begin
					mag_s4[k][j] <= mag[k][j];
					sgn_s4[k][j] <= n_s3[k][j][NW-1];
				end
				pos_s4[k] <= msb_pos(mx[k]);
			end
			degen_s4 <= (mx[0] == '0) || (mx[1] == '0);
			for (int j = 0; j < 3; j++) begin
				tph_s4[j] <= TPH_W'(tp_hi[j]) * TPH_W'(b3_s3[j]);
				tpl_s4[j] <= TPL_W'(tp_lo[j]) * TPL_W'(b3_s3[j]);
			end
		end
	end

	// S5: scale normals so the largest magnitude lands in [2^29, 2^30); triple sign
	logic [UMW-1:0]       mm [2][3];
	logic signed [TW-1:0] tot;
	always_comb begin
		for (int k = 0; k < 2; k++)
			for (int j = 0; j < 3; j++)
				if (pos_s4[k] >= 6'(NORM_MSB))
					mm[k][j] = UMW'(mag_s4[k][j] >> (pos_s4[k] - 6'(NORM_MSB)));
				else
					mm[k][j] = UMW'(mag_s4[k][j] << (6'(NORM_MSB) - pos_s4[k]));
		tot = (TW'(tph_s4[0]) + TW'(tph_s4[1]) + TW'(tph_s4[2])) <<< TP_SPLIT;
		tot = tot + TW'(tpl_s4[0]) + TW'(tpl_s4[1]) + TW'(tpl_s4[2]);
	end

	logic signed [UW-1:0] u_s5 [2][3];
	logic                 degen_s5, neg_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++)
				for (int j = 0; j < 3; j++)
					u_s5[k][j] <= sgn_s4[k][j] ? -$signed({1'b0, mm[k][j]})
						: $signed({1'b0, mm[k][j]});
			degen_s5 <= degen_s4;
			neg_s5   <= tot[TW-1];
		end
	end

	// S6: products of the normalized normals
	logic signed [UPW-1:0] ca_s6 [3], cb_s6 [3], dp_s6 [3];
	logic                  degen_s6, neg_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				ca_s6[j] <= UPW'(u_s5[0][NXT[j]]) * UPW'(u_s5[1][PRV[j]]);
				cb_s6[j] <= UPW'(u_s5[0][PRV[j]]) * UPW'(u_s5[1][NXT[j]]);
				dp_s6[j] <= UPW'(u_s5[0][j]) * UPW'(u_s5[1][j]);
			end
			degen_s6 <= degen_s5;
			neg_s6   <= neg_s5;
		end
	end

	// S7: truncate cross components and dot by 2^31
	logic signed [CCW-1:0]  cc [3];
	logic [CCW-1:0]         cmag [3];
	logic signed [DOTW-1:0] dot;
	logic [DOTW-1:0]        dmag;
	logic [XW-2:0]          xm;
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			cc[j]   = CCW'(ca_s6[j]) - CCW'(cb_s6[j]);
			cmag[j] = cc[j][CCW-1] ? CCW'(-cc[j]) : CCW'(cc[j]);
		end
		dot  = DOTW'(dp_s6[0]) + DOTW'(dp_s6[1]) + DOTW'(dp_s6[2]);
		dmag = dot[DOTW-1] ? DOTW'(-dot) : DOTW'(dot);
		xm   = dmag[XW+29:31];
	end

	logic [MW31-1:0]      m_s7 [3];
	logic signed [XW-1:0] x_s7;
	logic                 degen_s7, neg_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++)
				m_s7[j] <= cmag[j][MW31+30:31];
			x_s7     <= dot[DOTW-1] ? -$signed({1'b0, xm}) : $signed({1'b0, xm});
			degen_s7 <= degen_s6;
			neg_s7   <= neg_s6;
		end
	end

	// S8: squares
	logic [SQW-1:0]       sqm_s8 [3];
	logic signed [XW-1:0] x_s8;
	logic                 degen_s8, neg_s8;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++)
				sqm_s8[j] <= SQW'(m_s7[j]) * SQW'(m_s7[j]);
			x_s8     <= x_s7;
			degen_s8 <= degen_s7;
			neg_s8   <= neg_s7;
		end
	end

	// S9: radicand
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s9        <= RAD_W'(sqm_s8[0]) + RAD_W'(sqm_s8[1]) + RAD_W'(sqm_s8[2]);
			side_s9.x     <= x_s8;
			side_s9.degen <= degen_s8;
			side_s9.neg   <= neg_s8;
		end
	end
endmodule

### src/dau_sqrt_cell.sv
// One digit of the integer square root chain.
module dau_sqrt_cell (
	input  logic                      clk,
	input  logic                      en,
	input  logic [dau_pkg::RAD_W-1:0]  rad,
	input  logic [dau_pkg::REM_W-1:0]  rem,
	input  logic [dau_pkg::ROOT_W-1:0] root,
	input  dau_pkg::sq_side_t         side,
	output logic [dau_pkg::RAD_W-1:0]  rad_s1,
	output logic [dau_pkg::REM_W-1:0]  rem_s1,
	output logic [dau_pkg::ROOT_W-1:0] root_s1,
	output dau_pkg::sq_side_t         side_s1
);
	import dau_pkg::*;

	logic [REM_W-1:0] rem_n, trial;
	logic             ge;

	// bring down two radicand bits, try root*4+1
	assign rem_n = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
	assign trial = {root, 2'b01};
	assign ge    = rem_n >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1  <= {rad[RAD_W-3:0], 2'b00};
			rem_s1  <= ge ? rem_n - trial : rem_n;
			root_s1 <= {root[ROOT_W-2:0], ge};
			side_s1 <= side;
		end
	end
endmodule

### src/dau_cordic_cell.sv
// One vectoring iteration of the CORDIC chain.
module dau_cordic_cell #(
	parameter int SHIFT = 0
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [dau_pkg::DW-1:0] x,
	input  logic signed [dau_pkg::DW-1:0] y,
	input  logic signed [dau_pkg::DW-1:0] z,
	input  dau_pkg::rot_side_t           side,
	output logic signed [dau_pkg::DW-1:0] x_s1,
	output logic signed [dau_pkg::DW-1:0] y_s1,
	output logic signed [dau_pkg::DW-1:0] z_s1,
	output dau_pkg::rot_side_t           side_s1
);
	import dau_pkg::*;

	logic signed [DW-1:0] xs, ys, at;
	logic                 up;

	assign xs = x >>> SHIFT;
	assign ys = y >>> SHIFT;
	assign at = $signed(DW'(ATAN_Q30[SHIFT]));
	assign up = !y[DW-1] && (y != '0);

	always_ff @(posedge clk) begin
		if (en) begin
			if (up) begin
				x_s1 <= x + ys;
				y_s1 <= y - xs;
				z_s1 <= z + at;
			end else begin
				x_s1 <= x - ys;
				y_s1 <= y + xs;
				z_s1 <= z - at;
			end
			side_s1 <= side;
		end
	end
endmodule

### src/dihedral_angle_unit.sv
// Throughput: one item per cycle while the output skid slot is empty; the
// 32-cell square root chain and the 30-cell CORDIC chain are fully pipelined,
// one cell per stage.
// Reset (arst_n low, asynchronous): stage valid bits, the output skid slot and the
// degrees bit clear; the datapath registers hold no reset.
// Top level of the dihedral angle unit.
module dihedral_angle_unit #(
	parameter int ANGLE_FRAC_BITS = dau_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_wdata,
	dau_pts_if.sink        points,
	dau_ang_if.source      angles
);
	import dau_pkg::*;

	`include "dihedral_angle_unit_assert.svh"

	localparam int LAT = FRONT_LAT + SQRT_N + 1 + CORDIC_N + 2;
	localparam int SHD = 54 - ANGLE_FRAC_BITS;
	localparam int SHR = 30 - ANGLE_FRAC_BITS;
	// magnitude after scaling stays below 180 * 2^ANGLE_FRAC_BITS
	localparam int MW  = (ANGLE_FRAC_BITS + 9 > 25) ? ANGLE_FRAC_BITS + 9 : 25;
	localparam logic [MW-1:0] OMAX = MW'(OUT_MAX);

	// degrees/radians select; the user must write it only while idle, unchecked by the block
	logic deg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= 1'b0;
		end else if (cfg_we) begin
			deg_q <= cfg_wdata;
		end
	end

	// The whole pipe advances together. It freezes only when the skid slot
	// holds a beat, so one finished angle may wait while a new item enters.
	logic en;
	logic skid_v_q;
	logic [LAT-1:0] vld_q;

	assign en           = !skid_v_q;
	assign points.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], points.valid};
		end
	end

	// gather the point beat
	coord_t pt [4][3];
	always_comb begin
		pt[0][0] = points.p1_x; pt[0][1] = points.p1_y; pt[0][2] = points.p1_z;
		pt[1][0] = points.p2_x; pt[1][1] = points.p2_y; pt[1][2] = points.p2_z;
		pt[2][0] = points.p3_x; pt[2][1] = points.p3_y; pt[2][2] = points.p3_z;
		pt[3][0] = points.p4_x; pt[3][1] = points.p4_y; pt[3][2] = points.p4_z;
	end

	// normals, their cross and dot product, radicand for |n1 x n2|
	logic [RAD_W-1:0]  rad_c  [SQRT_N+1];
	logic [REM_W-1:0]  rem_c  [SQRT_N+1];
	logic [ROOT_W-1:0] root_c [SQRT_N+1];
	sq_side_t          sside_c [SQRT_N+1];

	dau_front u_front (
		.clk     (clk),
		.en      (en),
		.pt      (pt),
		.rad_s9  (rad_c[0]),
		.side_s9 (sside_c[0])
	);

	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	// square root chain: one result bit per cell
	for (genvar i = 0; i < SQRT_N; i++) begin : g_sqrt
		dau_sqrt_cell u_cell (
			.clk     (clk),
			.en      (en),
			.rad     (rad_c[i]),
			.rem     (rem_c[i]),
			.root    (root_c[i]),
			.side    (sside_c[i]),
			.rad_s1  (rad_c[i+1]),
			.rem_s1  (rem_c[i+1]),
			.root_s1 (root_c[i+1]),
			.side_s1 (sside_c[i+1])
		);
	end

	// Pre-rotation: a negative dot product is turned by a quarter turn so the
	// vectoring chain starts in the right half plane.
	logic signed [DW-1:0] cx_c [CORDIC_N+1];
	logic signed [DW-1:0] cy_c [CORDIC_N+1];
	logic signed [DW-1:0] cz_c [CORDIC_N+1];
	rot_side_t            rside_c [CORDIC_N+1];

	logic signed [DW-1:0] x_in, y_in;
	assign x_in = DW'(sside_c[SQRT_N].x);
	assign y_in = $signed(DW'(root_c[SQRT_N]));

	logic signed [DW-1:0] x_s42, y_s42, z_s42;
	rot_side_t            side_s42;
	always_ff @(posedge clk) begin
		if (en) begin
			if (x_in[DW-1]) begin
				x_s42 <= y_in;
				y_s42 <= -x_in;
				z_s42 <= $signed(DW'(HALF_PI_Q30));
			end else begin
				x_s42 <= x_in;
				y_s42 <= y_in;
				z_s42 <= '0;
			end
			side_s42.degen <= sside_c[SQRT_N].degen;
			side_s42.neg   <= sside_c[SQRT_N].neg;
		end
	end

	assign cx_c[0]    = x_s42;
	assign cy_c[0]    = y_s42;
	assign cz_c[0]    = z_s42;
	assign rside_c[0] = side_s42;

	// CORDIC vectoring chain: the angle gathers in Q2.30 radians
	for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
		dau_cordic_cell #(.SHIFT(i)) u_cell (
			.clk     (clk),
			.en      (en),
			.x       (cx_c[i]),
			.y       (cy_c[i]),
			.z       (cz_c[i]),
			.side    (rside_c[i]),
			.x_s1    (cx_c[i+1]),
			.y_s1    (cy_c[i+1]),
			.z_s1    (cz_c[i+1]),
			.side_s1 (rside_c[i+1])
		);
	end

	// clamp to [0, pi] and form the degree product
	logic signed [DW-1:0] zf;
	logic [ZCW-1:0]       zc;
	assign zf = cz_c[CORDIC_N];
	always_comb begin
		if (zf[DW-1])
			zc = '0;
		else if (zf > $signed(DW'(PI_Q30)))
			zc = PI_Q30;
		else
			zc = zf[ZCW-1:0];
	end

	logic [ZCW-1:0]   zc_s73;
	logic [PRODW-1:0] prod_s73;
	rot_side_t        side_s73;
	always_ff @(posedge clk) begin
		if (en) begin
			zc_s73   <= zc;
			prod_s73 <= PRODW'(zc) * PRODW'(DEG_PER_RAD_Q24);
			side_s73 <= rside_c[CORDIC_N];
		end
	end

	// round half up, apply sign, saturate; a degenerate item gives zero
	logic [PRODW:0]          rnd_d;
	logic [ZCW:0]            rnd_r;
	logic [MW-1:0]           m, msat;
	logic signed [OUT_W-1:0] ang;
	always_comb begin
		rnd_d = {1'b0, prod_s73} + ((PRODW+1)'(1) << (SHD - 1));
		rnd_r = {1'b0, zc_s73} + ((ZCW+1)'(1) << (SHR - 1));
		m     = deg_q ? MW'(rnd_d >> SHD) : MW'(rnd_r >> SHR);
		if (side_s73.neg) begin
			msat = (m > OMAX + MW'(1)) ? OMAX + MW'(1) : m;
			ang  = OUT_W'(MW'(0) - msat);
		end else begin
			msat = (m > OMAX) ? OMAX : m;
			ang  = OUT_W'(msat);
		end
		if (side_s73.degen)
			ang = '0;
	end

	logic signed [OUT_W-1:0] ang_s74;
	logic                    dgn_s74;
	always_ff @(posedge clk) begin
		if (en) begin
			ang_s74 <= ang;
			dgn_s74 <= side_s73.degen;
		end
	end

	// Output skid slot: catch the last stage's beat when the sink stalls, then
	// hold the pipe until that beat is taken.
	logic signed [OUT_W-1:0] skid_ang_q;
	logic                    skid_dgn_q;
	logic                    last_v;
	assign last_v = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (angles.ready) skid_v_q <= 1'b0;
		end else if (last_v && !angles.ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q && last_v && !angles.ready) begin
			skid_ang_q <= ang_s74;
			skid_dgn_q <= dgn_s74;
		end
	end

	assign angles.valid         = skid_v_q || last_v;
	assign angles.torsion_angle = skid_v_q ? skid_ang_q : ang_s74;
	assign angles.degenerate    = skid_v_q ? skid_dgn_q : dgn_s74;

	`DAU_ASSERT_NXT(a_skid_holds, clk, arst_n, skid_v_q && !angles.ready, skid_v_q)
	`DAU_ASSERT_NXT(a_skid_catch, clk, arst_n, !skid_v_q && last_v && !angles.ready, skid_v_q)
	`DAU_ASSERT_IMP(a_no_take_full, clk, arst_n, skid_v_q, !points.ready)
	`DAU_ASSERT_IMP(a_degen_zero, clk, arst_n, angles.valid && angles.degenerate, angles.torsion_angle == '0)
endmodule

### test/tb_dihedral_angle_unit.sv
// Testbench for dihedral_angle_unit: random and directed point sets checked against a predictor.
module tb_dihedral_angle_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import dau_pkg::*;

	// One point set: x, y, z of p1 to p4, in that order.
	typedef struct {
		coord_t c [12];
	} quad_t;

	// One angle beat as the output channel carries it.
	typedef struct {
		logic signed [OUT_W-1:0] angle;
		logic                    degen;
	} angle_t;

	// The scoreboard predicts each angle when its points are accepted
	// and checks every output beat against the oldest prediction.
	class angle_scoreboard;
		angle_t pending [$];
		int     errors;
		bit     in_degrees;

		function longint fdiv(longint v, int s);
			return v >>> s;
		endfunction

		function longint mshift(longint v, int l, int r);
			longint unsigned m;
			m = ((v < 0) ? -v : v);
			m = (m << l) >> r;
			return (v < 0) ? -longint'(m) : longint'(m);
		endfunction

		// Scale a normal so its largest magnitude lands in [2^29, 2^30).
		function bit unit_scale(ref longint v [3]);
			longint unsigned mx;
			int l, r;
			mx = 0; l = 0; r = 0;
			for (int i = 0; i < 3; i++)
				if (((v[i] < 0) ? -v[i] : v[i]) > mx)
					mx = (v[i] < 0) ? -v[i] : v[i];
			if (mx == 0)
				return 0;
			while (mx >= (64'd1 << 30)) begin
				mx >>= 1;
				r++;
			end
			while (mx < (64'd1 << 29)) begin
				mx <<= 1;
				l++;
			end
			for (int i = 0; i < 3; i++)
				v[i] = mshift(v[i], l, r);
			return 1;
		endfunction

		function longint unsigned floor_sqrt(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function angle_t torsion_of(quad_t q);
			angle_t a;
			longint b1 [3], b2 [3], b3 [3], n1 [3], n2 [3], c [3];
			logic signed [95:0] tp [3];
			logic signed [95:0] trip;
			longint x, y, z, t, dot, xs, ys;
			longint unsigned sq, m;
			for (int j = 0; j < 3; j++) begin
				b1[j] = longint'(q.c[j]) - longint'(q.c[3 + j]);
				b2[j] = longint'(q.c[9 + j]) - longint'(q.c[6 + j]);
				b3[j] = longint'(q.c[6 + j]) - longint'(q.c[3 + j]);
			end
			n1[0] = b3[1] * b2[2] - b3[2] * b2[1];
			n1[1] = b3[2] * b2[0] - b3[0] * b2[2];
			n1[2] = b3[0] * b2[1] - b3[1] * b2[0];
			n2[0] = b3[1] * b1[2] - b3[2] * b1[1];
			n2[1] = b3[2] * b1[0] - b3[0] * b1[2];
			n2[2] = b3[0] * b1[1] - b3[1] * b1[0];
			a.angle = '0;
			a.degen = 1'b1;
			if (!unit_scale(n1) || !unit_scale(n2))
				return a;
			c[0] = n1[1] * n2[2] - n1[2] * n2[1];
			c[1] = n1[2] * n2[0] - n1[0] * n2[2];
			c[2] = n1[0] * n2[1] - n1[1] * n2[0];
			sq = 0;
			for (int j = 0; j < 3; j++) begin
				m = ((c[j] < 0) ? -c[j] : c[j]) >> 31;
				sq += m * m;
			end
			y = longint'(floor_sqrt(sq));
			dot = n1[0] * n2[0] + n1[1] * n2[1] + n1[2] * n2[2];
			x = mshift(dot, 0, 31);
			z = 0;
			if (x < 0) begin
				t = x;
				x = y;
				y = -t;
				z = longint'(HALF_PI_Q30);
			end
			for (int i = 0; i < CORDIC_N; i++) begin
				xs = fdiv(x, i);
				ys = fdiv(y, i);
				if (y > 0) begin
					x += ys;
					y -= xs;
					z += longint'(ATAN_Q30[i]);
				end else begin
					x -= ys;
					y += xs;
					z -= longint'(ATAN_Q30[i]);
				end
			end
			if (z < 0)
				z = 0;
			if (z > longint'(PI_Q30))
				z = longint'(PI_Q30);
			if (in_degrees)
				m = (longint'(z) * longint'(DEG_PER_RAD_Q24)
					+ (64'd1 << (53 - ANGLE_FRAC_BITS_DEF))) >> (54 - ANGLE_FRAC_BITS_DEF);
			else
				m = (z + (64'd1 << (29 - ANGLE_FRAC_BITS_DEF))) >> (30 - ANGLE_FRAC_BITS_DEF);
			tp[0] = b1[1] * b2[2] - b1[2] * b2[1];
			tp[1] = b1[2] * b2[0] - b1[0] * b2[2];
			tp[2] = b1[0] * b2[1] - b1[1] * b2[0];
			trip = tp[0] * b3[0] + tp[1] * b3[1] + tp[2] * b3[2];
			if (trip < 0) begin
				if (m > OUT_MAX + 1)
					m = OUT_MAX + 1;
				m = -m;
			end else if (m > OUT_MAX) begin
				m = OUT_MAX;
			end
			a.angle = m[OUT_W-1:0];
			a.degen = 1'b0;
			return a;
		endfunction

		function void note_points(quad_t q);
			pending.push_back(torsion_of(q));
		endfunction

		function void check_angle(angle_t got);
			angle_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected angle beat %0d degenerate %0b",
					$time, got.angle, got.degen);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.angle !== want.angle) begin
				$display("%0t: angle mismatch expected %0d actual %0d",
					$time, want.angle, got.angle);
				errors++;
			end
			if (got.degen !== want.degen) begin
				$display("%0t: degenerate mismatch expected %0b actual %0b",
					$time, want.degen, got.degen);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	dau_pts_if points ();
	dau_ang_if angles ();

	dihedral_angle_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.points    (points.sink),
		.angles    (angles.source)
	);

	angle_scoreboard sb;
	bit quiet;  // when set, neither side idles

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block stops answering.
	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

	// Check every beat that the output channel hands over.
	always @(posedge clk) begin
		angle_t got;
		if (arst_n && angles.valid === 1'b1 && angles.ready === 1'b1) begin
			got.angle = angles.torsion_angle;
			got.degen = angles.degenerate;
			sb.check_angle(got);
		end
	end

	// Receiver: stall a random number of cycles, then hold ready until a beat lands.
	initial begin
		int n;
		angles.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = quiet ? 0 : $urandom_range(0, 5);
			if (n > 0) begin
				angles.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			angles.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(angles.valid === 1'b1 && angles.ready === 1'b1));
		end
	end

	// Present one point set after a random gap and hold it until accepted.
	task automatic send_points(quad_t q);
		int n;
		n = quiet ? 0 : $urandom_range(0, 5);
		if (n > 0) begin
			points.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		points.valid <= 1'b1;
		points.p1_x <= q.c[0];
		points.p1_y <= q.c[1];
		points.p1_z <= q.c[2];
		points.p2_x <= q.c[3];
		points.p2_y <= q.c[4];
		points.p2_z <= q.c[5];
		points.p3_x <= q.c[6];
		points.p3_y <= q.c[7];
		points.p3_z <= q.c[8];
		points.p4_x <= q.c[9];
		points.p4_y <= q.c[10];
		points.p4_z <= q.c[11];
		do
			@(posedge clk);
		while (points.ready !== 1'b1);
		sb.note_points(q);
	endtask

	// Drop valid, wait for every pending angle, then let the pipe empty.
	task automatic drain_pipe();
		points.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (FRONT_LAT + 90) @(posedge clk);
	endtask

	task automatic write_units(bit deg);
		cfg_we    <= 1'b1;
		cfg_wdata <= deg;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.in_degrees = deg;
	endtask

	function automatic quad_t make_quad(int a [12]);
		quad_t q;
		for (int i = 0; i < 12; i++)
			q.c[i] = coord_t'(a[i]);
		return q;
	endfunction

	// Random set; mode picks full range, small range, collinear or planar shapes.
	function automatic quad_t random_quad();
		quad_t q;
		int mode, span;
		mode = $urandom_range(0, 19);
		span = $urandom_range(1, 3) == 1 ? 255 : 40000;
		for (int i = 0; i < 12; i++)
			q.c[i] = (mode < 8) ? coord_t'($urandom)
				: coord_t'($urandom_range(0, 2 * span) - span);
		case (mode)
			16: begin
				for (int j = 0; j < 3; j++)
					q.c[6 + j] = q.c[3 + j];      // p3 on p2: both normals vanish
			end
			17: begin
				for (int j = 0; j < 3; j++)       // p1 on the middle bond line
					q.c[j] = q.c[3 + j] + 2 * (q.c[6 + j] - q.c[3 + j]);
			end
			18, 19: begin
				q.c[2]  = q.c[5];                 // all four points in one plane
				q.c[8]  = q.c[5];
				q.c[11] = q.c[5];
			end
			default: ;
		endcase
		return q;
	endfunction

	localparam int CMAX = 8388607;
	localparam int CMIN = -8388608;

	initial begin
		int one;
		sb = new();
		one = 4096;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = 1'b0;
		points.valid = 1'b0;
		points.p1_x = '0; points.p1_y = '0; points.p1_z = '0;
		points.p2_x = '0; points.p2_y = '0; points.p2_z = '0;
		points.p3_x = '0; points.p3_y = '0; points.p3_z = '0;
		points.p4_x = '0; points.p4_y = '0; points.p4_z = '0;
		quiet = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets, in radians and then in degrees.
		for (int u = 0; u < 2; u++) begin
			write_units(u[0]);
			send_points(make_quad('{0,0,0, 0,0,0, 0,0,0, 0,0,0}));           // all zero
			send_points(make_quad('{one,0,0, 0,0,0, 0,one,0, one,one,0}));   // cis, zero
			send_points(make_quad('{one,0,0, 0,0,0, 0,one,0, -one,one,0}));  // trans, pi
			send_points(make_quad('{one,0,0, 0,0,0, 0,one,0, 0,one,one}));   // -90
			send_points(make_quad('{one,0,0, 0,0,0, 0,one,0, 0,one,-one}));  // +90
			send_points(make_quad('{one,0,0, 0,0,0, 0,one,0, one,one,one})); // -45
			send_points(make_quad('{one,one,0, 0,0,0, 0,one,0, 0,2*one,0})); // p4 on bond line
			send_points(make_quad('{2*one,2*one,2*one, 0,0,0, one,one,one, 5,6,7}));
			send_points(make_quad('{CMAX,CMIN,CMAX, CMIN,CMIN,CMIN,
				CMAX,CMAX,CMAX, CMIN,CMAX,CMIN}));
			send_points(make_quad('{CMIN,CMAX,CMIN, CMAX,CMAX,CMAX,
				CMIN,CMIN,CMIN, CMAX,CMIN,CMAX}));
			send_points(make_quad('{CMAX,0,0, CMIN,0,0, CMIN,CMAX,0, CMAX,CMAX,1}));
			send_points(make_quad('{1,0,0, 0,0,0, 0,1,0, 1,1,-1}));         // tiny coordinates
			drain_pipe();
		end

		// Random phases; the drain between phases also stalls the sender.
		for (int ph = 0; ph < 4; ph++) begin
			write_units(ph == 1 || ph == 2);
			for (int i = 0; i < 440; i++) begin
				if (i % 110 == 0)
					quiet = ($urandom_range(0, 3) == 0);
				send_points(random_quad());
			end
			quiet = 0;
			drain_pipe();
		end

		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
